FILE: hw/rtl/crc32_string_id_hash_unit_assert.svh
// Assertion macros for the string id hash unit.
`ifndef CRC32_STRING_ID_HASH_UNIT_ASSERT_SVH
`define CRC32_STRING_ID_HASH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CSIH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csih assertion failed");

// Next-cycle implication.
`define CSIH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csih assertion failed");

`endif

FILE: hw/rtl/csih_pkg.sv
`timescale 1ns / 1ps

package csih_pkg;

   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
   localparam logic [7:0]  HASH_CHAR = 8'h23;
   localparam logic [1:0]  RUN_MAX   = 2'd3;

   typedef struct packed {
      logic [31:0] seed_value;
      logic [7:0]  data_byte;
      logic        has_byte;
      logic        first_byte;
      logic        last_byte;
   } req_word_type;

   // one byte of reflected CRC-32, LSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] v;
      v = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return v;
   endfunction

endpackage

FILE: hw/rtl/csih_in_stage.sv
`timescale 1ns / 1ps

module csih_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [31:0]           req_seed_value,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_has_byte,
   input  logic                  req_first_byte,
   input  logic                  req_last_byte,
   input  logic                  out_free,
   output logic                  fire,
   output csih_pkg::req_word_type word
);

   logic                  valid_ff;
   logic                  valid_in;
   csih_pkg::req_word_type word_ff;
   csih_pkg::req_word_type word_in;
   logic                  load;

   // a word carrying last_byte may only leave when the result register frees
   assign fire      = valid_ff && (!word_ff.last_byte || out_free);
   assign req_stall = reset || (valid_ff && !fire);
   assign load      = req_valid && !req_stall;
   assign word      = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (load) begin
         valid_in           = 1'b1;
         word_in.seed_value = req_seed_value;
         word_in.data_byte  = req_data_byte;
         word_in.has_byte   = req_has_byte;
         word_in.first_byte = req_first_byte;
         word_in.last_byte  = req_last_byte;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

FILE: hw/rtl/csih_hash_core.sv
`timescale 1ns / 1ps

module csih_hash_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  csih_pkg::req_word_type word,
   output logic [31:0]            hash_value
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] rst1_ff, rst1_in;
   logic [31:0] rst2_ff, rst2_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        seeded_ff, seeded_in;

   logic [31:0] inv_seed;
   logic [31:0] base_crc;
   logic [1:0]  base_cnt;
   logic [31:0] restart_crc;
   logic [31:0] stepped_crc;

   // restart value built one '#' per cycle; a third '#' cannot arrive sooner
   assign inv_seed    = ~word.seed_value;
   assign restart_crc = seeded_ff ? csih_pkg::crc_byte(rst2_ff, csih_pkg::HASH_CHAR) : 32'd0;
   assign base_crc    = word.first_byte ? inv_seed : crc_ff;
   assign base_cnt    = word.first_byte ? 2'd0 : cnt_ff;
   assign stepped_crc = csih_pkg::crc_byte(base_crc, word.data_byte);

   always_comb begin
      crc_in    = base_crc;
      cnt_in    = base_cnt;
      rst1_in   = rst1_ff;
      seeded_in = seeded_ff;
      rst2_in   = csih_pkg::crc_byte(rst1_ff, csih_pkg::HASH_CHAR);
      if (word.first_byte) begin
         rst1_in   = csih_pkg::crc_byte(inv_seed, csih_pkg::HASH_CHAR);
         seeded_in = 1'b1;
      end
      if (word.has_byte) begin
         if (word.data_byte == csih_pkg::HASH_CHAR) begin
            if (base_cnt != csih_pkg::RUN_MAX) begin
               cnt_in = base_cnt + 2'd1;
            end
            if (cnt_in == csih_pkg::RUN_MAX) begin
               crc_in = restart_crc;
            end else begin
               crc_in = stepped_crc;
            end
         end else begin
            cnt_in = 2'd0;
            crc_in = stepped_crc;
         end
      end
   end

   assign hash_value = ~crc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= 32'd0;
         cnt_ff    <= 2'd0;
         rst1_ff   <= 32'd0;
         rst2_ff   <= 32'd0;
         seeded_ff <= 1'b0;
      end else begin
         rst2_ff <= rst2_in;
         if (fire) begin
            crc_ff    <= crc_in;
            cnt_ff    <= cnt_in;
            rst1_ff   <= rst1_in;
            seeded_ff <= seeded_in;
         end
      end
   end

endmodule

FILE: hw/rtl/csih_out_stage.sv
`timescale 1ns / 1ps

module csih_out_stage (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [31:0] hash_value,
   output logic        out_free,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);

   logic        valid_ff, valid_in;
   logic [31:0] hash_ff, hash_in;

   assign out_free       = !valid_ff || !rsp_stall;
   assign rsp_valid      = valid_ff;
   assign rsp_hash_value = hash_ff;

   always_comb begin
      valid_in = valid_ff;
      hash_in  = hash_ff;
      if (load) begin
         valid_in = 1'b1;
         hash_in  = hash_value;
      end else if (out_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
   end

endmodule

FILE: hw/rtl/crc32_string_id_hash_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Word
// req_     in         req_valid/req_stall  seed, byte, has/first/last flags
// rsp_     out        rsp_valid/rsp_stall  32-bit hash, one per last_byte word
//
// One byte per cycle sustained while no stalled result holds back a last_byte word;
// the CRC step is a single byte-wide XOR network between input and result register.
// Synchronous reset clears hash state to zero; req_stall is held high during reset.
// A stalled result blocks the next last_byte word, and every word after it.
module crc32_string_id_hash_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_seed_value,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);

   csih_pkg::req_word_type word;
   logic                   fire;
   logic                   out_free;
   logic [31:0]            hash_value;

   csih_in_stage u_in (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_seed_value (req_seed_value),
      .req_data_byte  (req_data_byte),
      .req_has_byte   (req_has_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .out_free       (out_free),
      .fire           (fire),
      .word           (word)
   );

   csih_hash_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .word       (word),
      .hash_value (hash_value)
   );

   csih_out_stage u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (fire && word.last_byte),
      .hash_value     (hash_value),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

FILE: hw/rtl/csih_checker.sv
`timescale 1ns / 1ps
`include "crc32_string_id_hash_unit_assert.svh"

module csih_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [31:0] req_seed_value,
   input logic        req_has_byte,
   input logic        req_first_byte,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_hash_value
);

   `CSIH_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `CSIH_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_hash_value))
   // fresh result on idle output: last_byte word via input, then result register
   `CSIH_ASSERT_NOW(a_rsp_source, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall && req_last_byte, 2))
   // empty string hashes to its seed
   `CSIH_ASSERT_NOW(a_empty_seed, clock, reset, $rose(rsp_valid) && $past(req_first_byte && !req_has_byte, 2), rsp_hash_value == $past(req_seed_value, 2))

endmodule

bind crc32_string_id_hash_unit csih_checker u_csih_checker (.*);

FILE: tb/sv/tb_crc32_string_id_hash_unit.sv
`timescale 1ns / 1ps

module tb_crc32_string_id_hash_unit;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 440;
   localparam int TAIL_WORDS   = 60;
   localparam int DRAIN_LIMIT  = 2000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_seed_value;
   logic [7:0]  req_data_byte;
   logic        req_has_byte;
   logic        req_first_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_hash_value;

   // predictor state
   logic [31:0] crc_state;
   logic [31:0] seed_inverse;
   logic [31:0] hash_restart;
   logic [1:0]  hash_run;

   logic [31:0] expected_hash_q[$];
   logic [31:0] want_hash;
   int          error_count;
   int          sent_count;
   int          cycle_count;
   int          stall_left;
   bit          quiet_tail;

   crc32_string_id_hash_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_seed_value (req_seed_value),
      .req_data_byte  (req_data_byte),
      .req_has_byte   (req_has_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t: %s got %08h want %08h", $realtime, what, got, want);
      error_count++;
   endtask

   // reflected CRC-32, one data bit per step
   function automatic logic [31:0] fold_crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] acc;
      acc = crc;
      for (int k = 0; k < 8; k++) begin
         if (acc[0] ^ b[k]) begin
            acc = (acc >> 1) ^ csih_pkg::CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

   task automatic predict_hash(input csih_pkg::req_word_type w);
      if (w.first_byte) begin
         seed_inverse = ~w.seed_value;
         crc_state    = seed_inverse;
         hash_restart = fold_crc_byte(fold_crc_byte(fold_crc_byte(seed_inverse,
                           csih_pkg::HASH_CHAR), csih_pkg::HASH_CHAR), csih_pkg::HASH_CHAR);
         hash_run     = 2'd0;
      end
      if (w.has_byte) begin
         if (w.data_byte == csih_pkg::HASH_CHAR) begin
            if (hash_run != csih_pkg::RUN_MAX) hash_run++;
            crc_state = (hash_run == csih_pkg::RUN_MAX) ? hash_restart
                                                        : fold_crc_byte(crc_state, w.data_byte);
         end else begin
            hash_run  = 2'd0;
            crc_state = fold_crc_byte(crc_state, w.data_byte);
         end
      end
      if (w.last_byte) expected_hash_q = {expected_hash_q, ~crc_state};
   endtask

   // entered, left at a falling edge; valid drops only in random gaps
   task automatic send_word(input logic [31:0] seed, input logic [7:0] data,
                            input logic has, input logic first, input logic last);
      csih_pkg::req_word_type w;
      int                     gap;
      w.seed_value = seed;
      w.data_byte  = data;
      w.has_byte   = has;
      w.first_byte = first;
      w.last_byte  = last;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         gap       = $urandom_range(1, 5);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_seed_value = w.seed_value;
      req_data_byte  = w.data_byte;
      req_has_byte   = w.has_byte;
      req_first_byte = w.first_byte;
      req_last_byte  = w.last_byte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_hash(w);
      sent_count++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return csih_pkg::HASH_CHAR;
      if (r < 40) return 8'h00;
      if (r < 45) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_string(input int len, input bit with_first, input bit with_last,
                              input bit noisy);
      logic has;
      logic first;
      logic last;
      for (int i = 0; i < len; i++) begin
         has   = ($urandom_range(0, 15) != 0);
         first = with_first && (i == 0);
         last  = with_last && (i == len - 1);
         if (noisy) begin
            first = ($urandom_range(0, 5) == 0);
            last  = ($urandom_range(0, 3) == 0);
         end
         send_word($urandom, pick_byte(), has, first, last);
      end
   endtask

   // receiver back-pressure
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_stall  = 1'b1;
            stall_left = $urandom_range(0, 4);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hash_q.size() == 0) begin
            report_mismatch("unexpected hash_value", rsp_hash_value, 32'h0);
         end else begin
            want_hash = expected_hash_q.pop_front();
            if (rsp_hash_value !== want_hash)
               report_mismatch("hash_value", rsp_hash_value, want_hash);
         end
      end
   end

   // state is all zero straight after reset, restart value included
   task automatic test_unmarked_after_reset();
      send_word($urandom, 8'h61, 1'b1, 1'b0, 1'b1);
      send_word($urandom, csih_pkg::HASH_CHAR, 1'b1, 1'b0, 1'b0);
      send_word($urandom, csih_pkg::HASH_CHAR, 1'b1, 1'b0, 1'b0);
      send_word($urandom, csih_pkg::HASH_CHAR, 1'b1, 1'b0, 1'b1);
   endtask

   task automatic test_empty_strings();
      send_word(32'h0000_0000, 8'hFF, 1'b0, 1'b1, 1'b1);
      send_word(32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1, 1'b1);
   endtask

   task automatic test_byte_extremes();
      send_word(32'hFFFF_FFFF, 8'h00, 1'b1, 1'b1, 1'b0);
      send_word(32'h0000_0000, 8'hFF, 1'b1, 1'b0, 1'b0);
      send_word(32'h0000_0000, 8'hFF, 1'b0, 1'b0, 1'b0);
      send_word(32'h0000_0000, 8'h00, 1'b1, 1'b0, 1'b1);
      send_word(32'h0000_0000, 8'hFF, 1'b1, 1'b1, 1'b1);
   endtask

   task automatic test_hash_runs();
      send_word(32'h1234_5678, csih_pkg::HASH_CHAR, 1'b1, 1'b1, 1'b0);
      send_word(32'h0, csih_pkg::HASH_CHAR, 1'b1, 1'b0, 1'b0);
      send_word(32'h0, 8'h61, 1'b1, 1'b0, 1'b0);
      send_word(32'h0, csih_pkg::HASH_CHAR, 1'b1, 1'b0, 1'b0);
      send_word(32'h0, csih_pkg::HASH_CHAR, 1'b1, 1'b0, 1'b0);
      send_word(32'h0, csih_pkg::HASH_CHAR, 1'b1, 1'b0, 1'b0);
      send_word(32'h0, csih_pkg::HASH_CHAR, 1'b1, 1'b0, 1'b1);
   endtask

   task automatic test_continue_after_last();
      send_word($urandom, 8'h62, 1'b1, 1'b0, 1'b1);
      send_word($urandom, 8'h62, 1'b0, 1'b0, 1'b1);
   endtask

   task automatic test_restart_mid_string();
      send_word(32'hA5A5_5A5A, 8'h71, 1'b1, 1'b1, 1'b0);
      send_word(32'h5A5A_A5A5, csih_pkg::HASH_CHAR, 1'b1, 1'b1, 1'b1);
   endtask

   task automatic test_random_strings();
      int stop_at;
      int r;
      stop_at = sent_count + RANDOM_WORDS;
      while (sent_count < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 5)       send_word($urandom, pick_byte(), 1'b0, 1'b1, 1'b1);
         else if (r < 85) send_string($urandom_range(1, 10), 1'b1, 1'b1, 1'b0);
         else if (r < 92) send_string($urandom_range(1, 6), 1'b0, 1'b1, 1'b0);
         else             send_string($urandom_range(1, 8), 1'b0, 1'b0, 1'b1);
      end
   endtask

   task automatic test_quiet_tail();
      int stop_at;
      quiet_tail = 1'b1;
      stop_at    = sent_count + TAIL_WORDS;
      while (sent_count < stop_at) send_string($urandom_range(1, 8), 1'b1, 1'b1, 1'b0);
   endtask

   initial begin
      int drain;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_seed_value = 32'h0;
      req_data_byte  = 8'h0;
      req_has_byte   = 1'b0;
      req_first_byte = 1'b0;
      req_last_byte  = 1'b0;
      crc_state      = 32'h0;
      seed_inverse   = 32'h0;
      hash_restart   = 32'h0;
      hash_run       = 2'd0;
      error_count    = 0;
      sent_count     = 0;
      quiet_tail     = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_unmarked_after_reset();
      test_empty_strings();
      test_byte_extremes();
      test_hash_runs();
      test_continue_after_last();
      test_restart_mid_string();
      test_random_strings();
      test_quiet_tail();
      req_valid = 1'b0;

      drain = 0;
      while (expected_hash_q.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      if (expected_hash_q.size() != 0)
         report_mismatch("hashes never returned", 32'(expected_hash_q.size()), 32'h0);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
